// ===== rtl/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

  // Widths fixed by the stream format.
  localparam int unsigned LimitW     = 13;
  localparam int unsigned PathLenW   = 12;
  localparam int unsigned ShiftW     = 7;
  localparam int unsigned SizeW      = 64;
  localparam int unsigned DefVarintBits = 64;

  // Configuration register reset value and the ceiling applied to it.
  localparam logic [LimitW-1:0] PathLimitReset = 13'd2048;
  localparam logic [LimitW-1:0] PathLimitMax   = 13'd4096;

  // Register index of the path limit on the configuration port.
  localparam logic RegPathLimit = 1'b0;

  // Input commands.
  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // Tag byte values.
  localparam logic [7:0] TagFile = 8'd0;
  localparam logic [7:0] TagDir  = 8'd1;

  // Byte classes reported with each result.
  localparam logic [2:0] ClsTag   = 3'd0;
  localparam logic [2:0] ClsPlen  = 3'd1;
  localparam logic [2:0] ClsPath  = 3'd2;
  localparam logic [2:0] ClsSize  = 3'd3;
  localparam logic [2:0] ClsBody  = 3'd4;
  localparam logic [2:0] ClsNone  = 3'd5;

  // Sticky error codes.
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrBadTag    = 3'd1;
  localparam logic [2:0] ErrOverflow  = 3'd2;
  localparam logic [2:0] ErrPathLong  = 3'd3;
  localparam logic [2:0] ErrTruncated = 3'd4;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_TAG  = 5'b00001,
    PH_PLEN = 5'b00010,
    PH_PATH = 5'b00100,
    PH_SIZE = 5'b01000,
    PH_BODY = 5'b10000
  } phase_e;

  // Input transaction payload.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0]          byte_class;
    logic [7:0]          data_out;
    logic                header_done;
    logic                entry_is_dir;
    logic [PathLenW-1:0] path_length;
    logic [SizeW-1:0]    file_size;
    logic                file_end;
    logic [2:0]          error_code;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/entry_stream_deframer.sv =====
// Entry stream deframer.
// Takes an archive entry stream one byte per input transaction (cmd 0) and
// classifies each byte as tag, path length varint, path, size varint or body.
// Path and body bytes are passed through; header_done pulses when an entry
// header is complete and file_end when a file's last body byte is taken (or
// a zero-size file header completes). An end-of-stream check (cmd 1) flags a
// partly taken entry as truncated. Errors are sticky until reset.
// Every input transaction yields exactly one result transaction.
// The path is an input register, then the parser logic feeding the
// result register. One transaction is accepted every cycle unless the
// receiver stalls; the parser state is a single set of registers updated as
// each byte leaves the input register, so consecutive bytes need no bubbles.
// When the receiver stalls, the result register holds and the input register
// fills; after that in_ready_o drops until the result is taken.
// Reset empties both registers, returns the parser to expecting a tag with no
// error, and sets path_limit to 2048. The APB port holds path_limit at
// address 0; values above 4096 act as 4096.
`default_nettype none

module entry_stream_deframer
  import esd_pkg::*;
#(
  parameter int unsigned VARINT_BITS = DefVarintBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [ShiftW-1:0] VarintLimit = ShiftW'(VARINT_BITS);
  localparam logic [ShiftW-1:0] ShiftStep   = ShiftW'(7);

  // Configuration register.
  logic [LimitW-1:0] path_limit_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPathLimit) ? 32'(path_limit_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_limit_q <= PathLimitReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegPathLimit)) begin
      path_limit_q <= pwdata[LimitW-1:0];
    end
  end

  // Handshake for the two register stages.
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  logic      fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
  end

  // Parser state.
  phase_e                 phase_q, phase_d;
  logic [VARINT_BITS-1:0] acc_q, acc_d;
  logic [ShiftW-1:0]      shift_q, shift_d;
  logic [PathLenW-1:0]    path_left_q, path_left_d;
  logic [VARINT_BITS-1:0] body_left_q, body_left_d;
  logic                   dir_q, dir_d;
  logic [PathLenW-1:0]    held_plen_q, held_plen_d;
  logic [VARINT_BITS-1:0] held_size_q, held_size_d;
  logic [2:0]             err_q, err_d;

  // Varint step shared by both length fields.
  logic [LimitW-1:0]      limit;
  logic [VARINT_BITS-1:0] acc_new;
  logic [ShiftW-1:0]      shift_inc;
  logic                   vi_cont;
  logic                   vi_ovf;
  logic                   plen_too_long;
  logic [7:0]             byte_in;

  assign byte_in   = s1_item_q.data_byte;
  assign limit     = (path_limit_q > PathLimitMax) ? PathLimitMax : path_limit_q;
  assign acc_new   = acc_q | (VARINT_BITS'(byte_in[6:0]) << shift_q);
  assign shift_inc = shift_q + ShiftStep;
  assign vi_cont   = byte_in[7];
  assign vi_ovf    = vi_cont && (shift_inc >= VarintLimit);
  assign plen_too_long = (|acc_new[VARINT_BITS-1:LimitW]) || (acc_new[LimitW-1:0] >= limit);

  logic [2:0] cls;
  logic [7:0] dout;
  logic       hdone;
  logic       fend;

  // Next state and result for the transaction leaving the input register.
  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    shift_d     = shift_q;
    path_left_d = path_left_q;
    body_left_d = body_left_q;
    dir_d       = dir_q;
    held_plen_d = held_plen_q;
    held_size_d = held_size_q;
    err_d       = err_q;
    cls         = ClsNone;
    dout        = 8'd0;
    hdone       = 1'b0;
    fend        = 1'b0;

    if (s1_item_q.cmd == CmdEnd) begin
      if ((err_q == ErrNone) && (phase_q != PH_TAG)) begin
        err_d = ErrTruncated;
      end
    end else if (err_q == ErrNone) begin
      unique case (phase_q)
        PH_PLEN: begin
          cls   = ClsPlen;
          acc_d = acc_new;
          if (vi_ovf) begin
            err_d = ErrOverflow;
          end else if (vi_cont) begin
            shift_d = shift_inc;
          end else if (plen_too_long) begin
            err_d = ErrPathLong;
          end else begin
            held_plen_d = acc_new[PathLenW-1:0];
            path_left_d = acc_new[PathLenW-1:0];
            acc_d       = '0;
            shift_d     = '0;
            if (acc_new[PathLenW-1:0] != '0) begin
              phase_d = PH_PATH;
            end else if (dir_q) begin
              hdone   = 1'b1;
              phase_d = PH_TAG;
            end else begin
              phase_d = PH_SIZE;
            end
          end
        end
        PH_PATH: begin
          cls         = ClsPath;
          dout        = byte_in;
          path_left_d = path_left_q - PathLenW'(1);
          if (path_left_q == PathLenW'(1)) begin
            if (dir_q) begin
              hdone   = 1'b1;
              phase_d = PH_TAG;
            end else begin
              phase_d = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          cls   = ClsSize;
          acc_d = acc_new;
          if (vi_ovf) begin
            err_d = ErrOverflow;
          end else if (vi_cont) begin
            shift_d = shift_inc;
          end else begin
            held_size_d = acc_new;
            body_left_d = acc_new;
            acc_d       = '0;
            shift_d     = '0;
            hdone       = 1'b1;
            if (acc_new == '0) begin
              fend    = 1'b1;
              phase_d = PH_TAG;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          cls         = ClsBody;
          dout        = byte_in;
          body_left_d = body_left_q - VARINT_BITS'(1);
          if (body_left_q == VARINT_BITS'(1)) begin
            fend    = 1'b1;
            phase_d = PH_TAG;
          end
        end
        PH_TAG: begin
          cls         = ClsTag;
          acc_d       = '0;
          shift_d     = '0;
          path_left_d = '0;
          body_left_d = '0;
          held_plen_d = '0;
          held_size_d = '0;
          if ((byte_in != TagFile) && (byte_in != TagDir)) begin
            dir_d = 1'b0;
            err_d = ErrBadTag;
          end else begin
            dir_d   = (byte_in == TagDir);
            phase_d = PH_PLEN;
          end
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      acc_q       <= '0;
      shift_q     <= '0;
      path_left_q <= '0;
      body_left_q <= '0;
      dir_q       <= 1'b0;
      held_plen_q <= '0;
      held_size_q <= '0;
      err_q       <= ErrNone;
    end else if (fire) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      shift_q     <= shift_d;
      path_left_q <= path_left_d;
      body_left_q <= body_left_d;
      dir_q       <= dir_d;
      held_plen_q <= held_plen_d;
      held_size_q <= held_size_d;
      err_q       <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q.byte_class   <= cls;
      out_item_q.data_out     <= dout;
      out_item_q.header_done  <= hdone;
      out_item_q.entry_is_dir <= dir_d;
      out_item_q.path_length  <= held_plen_d;
      out_item_q.file_size    <= SizeW'(held_size_d);
      out_item_q.file_end     <= fend;
      out_item_q.error_code   <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // Checks on the parser.
  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |=> (err_q == $past(err_q)))
    else $error("sticky error changed");

  a_phase_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parser phase not one-hot");

  a_hdone_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.header_done) |-> (out_item_q.error_code == ErrNone))
    else $error("header completed alongside an error");

  a_fend_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.file_end) |->
      ((out_item_q.byte_class == ClsSize) || (out_item_q.byte_class == ClsBody)))
    else $error("file end on a byte outside size or body");

endmodule

`default_nettype wire
